// File: src/lfu_pkg.sv
// shared constants for the lfu cache table
package lfu_pkg;

	// field widths of a request and a response
	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	// default sizing of the table
	localparam int ENTRIES_DEF    = 16;
	localparam int COUNT_BITS_DEF = 16;

	// capacity register after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request kinds
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

endpackage

// File: src/lfu_cache_table_core.sv
// lfu cache table: key-value store with least-frequently-used replacement
//
// Each request (get or put, one per transfer on the s_ side) walks the table
// twice through one read port per ram: a scan pass that compares every entry
// against the key and keeps the running victim (lowest use count, oldest
// touch on ties) and the first free slot, then, when the request changes the
// table, a recency pass that rewrites the touch ranks of the entries; a get
// miss and a put with capacity zero skip that pass. The next request is taken
// once the response is registered, while the response waits for its
// transfer. Use counts saturate at 2^COUNT_BITS - 1. The capacity register
// is to be written only while no request is in flight; the block itself does
// not enforce this. Values above ENTRIES act as ENTRIES.
module lfu_cache_table_core #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// capacity register
	input  logic                                     cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]                cfg_wdata,
	// request stream
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [lfu_pkg::KEY_W+lfu_pkg::DATA_W-1:0] s_tdata,  // req_key, req_data
	input  logic                                     s_tuser,  // kind
	// response stream
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [lfu_pkg::DATA_W+lfu_pkg::KEY_W-1:0] m_tdata,  // read_data, evicted_key
	output logic [1:0]                               m_tuser   // hit, evicted
);

	import lfu_pkg::*;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PTR_W  = $clog2(ENTRIES + 1);
	localparam int OCC_W  = PTR_W;
	localparam int ENT_W  = KEY_W + DATA_W + COUNT_BITS;
	localparam int CAPX_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	localparam logic [PTR_W-1:0]      PTR_END   = PTR_W'(ENTRIES);
	localparam logic [CAPX_W-1:0]     CAP_MAX   = CAPX_W'(ENTRIES);
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]         state_q;
	logic [PTR_W-1:0]   ptr_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [CAP_W-1:0]   cap_q;
	logic [OCC_W-1:0]   occ_q;
	logic [ENTRIES-1:0] valid_q;

	// request being served
	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;

	// scan results
	logic                  match_q;
	logic [IDX_W-1:0]      sidx_q;
	logic [DATA_W-1:0]     sdata_q;
	logic [COUNT_BITS-1:0] scnt_q;
	logic [IDX_W-1:0]      srec_q;
	logic                  vic_q;
	logic [IDX_W-1:0]      vidx_q;
	logic [KEY_W-1:0]      vkey_q;
	logic [COUNT_BITS-1:0] vcnt_q;
	logic [IDX_W-1:0]      vrec_q;
	logic                  free_q;
	logic [IDX_W-1:0]      fidx_q;

	// recency pass control
	logic [IDX_W-1:0] tgt_q;
	logic [IDX_W-1:0] old_q;
	logic             inc_all_q;

	// response
	logic              res_hit_q;
	logic [DATA_W-1:0] res_rd_q;
	logic              res_ev_q;
	logic [KEY_W-1:0]  res_evk_q;
	logic              m_tvalid_q;
	logic              out_hit_q;
	logic [DATA_W-1:0] out_rd_q;
	logic              out_ev_q;
	logic [KEY_W-1:0]  out_evk_q;

	// ram ports
	logic              ent_we;
	logic [IDX_W-1:0]  ent_waddr;
	logic [ENT_W-1:0]  ent_wdata;
	logic [ENT_W-1:0]  ent_rdata;
	logic              rec_we;
	logic [IDX_W-1:0]  rec_wdata;
	logic [IDX_W-1:0]  rec_rdata;
	logic [IDX_W-1:0]  rd_addr;

	// entry under compare
	logic                  cur_valid;
	logic [KEY_W-1:0]      cur_key;
	logic [DATA_W-1:0]     cur_data;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic                  issue;
	logic                  pass_done;
	logic                  scan_hit;
	logic                  scan_vic;
	logic                  scan_free;

	// decision
	logic [CAPX_W-1:0]     cap_ext;
	logic [CAPX_W-1:0]     cap_eff;
	logic                  full;
	logic                  put_ok;
	logic                  upd;
	logic                  evict;
	logic                  ins_free;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [DATA_W-1:0]     new_data;
	logic [IDX_W-1:0]      new_tgt;

	assign rd_addr   = ptr_q[IDX_W-1:0];
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && (ptr_q != PTR_END);
	assign pass_done = (ptr_q == PTR_END) && !rd_vld_s1;

	// field split of the entry word
	assign cur_valid = valid_q[rd_idx_s1];
	assign cur_key   = ent_rdata[KEY_W-1:0];
	assign cur_data  = ent_rdata[KEY_W+DATA_W-1:KEY_W];
	assign cur_cnt   = ent_rdata[ENT_W-1:KEY_W+DATA_W];

	// per-entry compare during the scan pass
	assign scan_hit  = (state_q == ST_SCAN) && rd_vld_s1 && cur_valid && !match_q
		&& (cur_key == key_q);
	assign scan_vic  = (state_q == ST_SCAN) && rd_vld_s1 && cur_valid
		&& (!vic_q || (cur_cnt < vcnt_q) || ((cur_cnt == vcnt_q) && (rec_rdata > vrec_q)));
	assign scan_free = (state_q == ST_SCAN) && rd_vld_s1 && !cur_valid && !free_q;

	// what the request does to the table
	assign cap_ext  = CAPX_W'(cap_q);
	assign cap_eff  = (cap_ext > CAP_MAX) ? CAP_MAX : cap_ext;
	assign full     = CAPX_W'(occ_q) >= cap_eff;
	assign put_ok   = (kind_q == KIND_PUT) && (cap_eff != '0);
	assign upd      = (match_q && (kind_q == KIND_GET)) || put_ok;
	assign evict    = put_ok && !match_q && full;
	assign ins_free = put_ok && !match_q && !full;
	assign new_cnt  = !match_q ? COUNT_ONE
		: ((scnt_q == COUNT_TOP) ? scnt_q : scnt_q + COUNT_ONE);
	assign new_data = (kind_q == KIND_PUT) ? data_q : sdata_q;
	assign new_tgt  = match_q ? sidx_q : (full ? vidx_q : fidx_q);

	// entry write once the decision is made
	assign ent_we    = (state_q == ST_DECIDE) && upd;
	assign ent_waddr = new_tgt;
	assign ent_wdata = {new_cnt, new_data, key_q};

	// recency rewrite: the touched entry goes to zero, younger ones age by one
	assign rec_we    = (state_q == ST_UPDATE) && rd_vld_s1
		&& ((rd_idx_s1 == tgt_q) || (cur_valid && (inc_all_q || (rec_rdata < old_q))));
	assign rec_wdata = (rd_idx_s1 == tgt_q) ? '0 : rec_rdata + 1'b1;

	lfu_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (rd_addr),
		.rdata (ent_rdata)
	);

	lfu_ram #(
		.WIDTH (IDX_W),
		.DEPTH (ENTRIES)
	) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rd_idx_s1),
		.wdata (rec_wdata),
		.raddr (rd_addr),
		.rdata (rec_rdata)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
	end

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			occ_q      <= '0;
			valid_q    <= '0;
			match_q    <= 1'b0;
			vic_q      <= 1'b0;
			free_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// response valid: raised by the finish step, dropped on its transfer
			if ((state_q == ST_FINISH) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ptr_q   <= '0;
						match_q <= 1'b0;
						vic_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (scan_hit) begin
						match_q <= 1'b1;
					end
					if (scan_vic) begin
						vic_q <= 1'b1;
					end
					if (scan_free) begin
						free_q <= 1'b1;
					end
					if (pass_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (ins_free) begin
						valid_q[fidx_q] <= 1'b1;
						occ_q           <= occ_q + 1'b1;
					end
					ptr_q   <= '0;
					state_q <= upd ? ST_UPDATE : ST_FINISH;
				end
				ST_UPDATE: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (pass_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_tvalid) begin
			kind_q <= s_tuser;
			key_q  <= s_tdata[KEY_W-1:0];
			data_q <= s_tdata[KEY_W+DATA_W-1:KEY_W];
		end
		if (scan_hit) begin
			sidx_q  <= rd_idx_s1;
			sdata_q <= cur_data;
			scnt_q  <= cur_cnt;
			srec_q  <= rec_rdata;
		end
		if (scan_vic) begin
			vidx_q <= rd_idx_s1;
			vkey_q <= cur_key;
			vcnt_q <= cur_cnt;
			vrec_q <= rec_rdata;
		end
		if (scan_free) begin
			fidx_q <= rd_idx_s1;
		end
		if (state_q == ST_DECIDE) begin
			tgt_q     <= new_tgt;
			old_q     <= match_q ? srec_q : vrec_q;
			inc_all_q <= ins_free;
			res_hit_q <= match_q;
			res_rd_q  <= (match_q && (kind_q == KIND_GET)) ? sdata_q : '0;
			res_ev_q  <= evict;
			res_evk_q <= evict ? vkey_q : '0;
		end
		if ((state_q == ST_FINISH) && (!m_tvalid_q || m_tready)) begin
			out_hit_q <= res_hit_q;
			out_rd_q  <= res_rd_q;
			out_ev_q  <= res_ev_q;
			out_evk_q <= res_evk_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_evk_q, out_rd_q};
	assign m_tuser  = {out_ev_q, out_hit_q};

	// occupancy tracks the number of valid entries
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy out of step with valid entries");

	// occupancy never exceeds the table size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("occupancy above table size");

	// a response appears only after the finish step
	a_resp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FINISH))
		else $error("response raised outside finish");

	// an eviction never goes with a hit
	a_evict_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_ev_q) |-> !out_hit_q)
		else $error("eviction reported on a hit");

	// a free-slot insert grows occupancy by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DECIDE) && ins_free) |=> (occ_q == $past(occ_q) + 1'b1))
		else $error("insert did not grow occupancy");

endmodule

// File: src/lfu_ram.sv
// generic simple dual-port ram with registered read
module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: verif/lfu_cache_checker.sv
`timescale 1ns / 1ps
// lfu cache table checker: mirrors the table state and compares every response transfer
module lfu_cache_checker #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]                 cfg_wdata,
	input  logic                                      s_tvalid,
	input  logic                                      s_tready,
	input  logic [lfu_pkg::KEY_W+lfu_pkg::DATA_W-1:0] s_tdata,  // req_key, req_data
	input  logic                                      s_tuser,  // kind
	input  logic                                      m_tvalid,
	input  logic                                      m_tready,
	input  logic [lfu_pkg::DATA_W+lfu_pkg::KEY_W-1:0] m_tdata,  // read_data, evicted_key
	input  logic [1:0]                                m_tuser,  // hit, evicted
	output int                                        error_count,
	output int                                        in_flight
);
	import lfu_pkg::*;

	localparam int REPLY_DEPTH = 8;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_data;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
	} cache_reply_t;

	// mirror of the table
	logic                  slot_used [ENTRIES];
	logic [KEY_W-1:0]      slot_key  [ENTRIES];
	logic [DATA_W-1:0]     slot_data [ENTRIES];
	logic [COUNT_BITS-1:0] slot_uses [ENTRIES];
	int unsigned           slot_rank [ENTRIES];
	int unsigned           fill_level;
	logic [CAP_W-1:0]      capacity;

	// expected responses in request order
	cache_reply_t reply_fifo [REPLY_DEPTH];
	int           reply_rd;
	int           reply_wr;
	int           reply_cnt;

	// bring an entry to the front of the touch order and bump its use count
	function automatic void touch_slot(int s);
		int unsigned prior;
		int j;
		prior = slot_rank[s];
		for (j = 0; j < ENTRIES; j++) begin
			if (slot_used[j] && j != s && slot_rank[j] < prior)
				slot_rank[j]++;
		end
		slot_rank[s] = 0;
		if (slot_uses[s] != '1)
			slot_uses[s]++;
	endfunction

	// apply one request to the mirror and return the response it should give
	function automatic cache_reply_t serve_request(logic kind, logic [KEY_W-1:0] key,
			logic [DATA_W-1:0] data);
		cache_reply_t r;
		int unsigned  cap;
		int unsigned  gone_rank;
		int           slot;
		int           victim;
		int           j;
		r = '0;
		cap = (capacity > ENTRIES) ? ENTRIES : capacity;
		slot = -1;
		for (j = 0; j < ENTRIES; j++) begin
			if (slot < 0 && slot_used[j] && slot_key[j] == key)
				slot = j;
		end
		r.hit = (slot >= 0);

		if (kind == KIND_GET) begin
			if (slot >= 0) begin
				r.read_data = slot_data[slot];
				touch_slot(slot);
			end
		end else if (cap != 0) begin
			if (slot >= 0) begin
				slot_data[slot] = data;
				touch_slot(slot);
			end else begin
				// full: drop the least used entry, the oldest touched on a tie
				if (fill_level >= cap) begin
					victim = -1;
					for (j = 0; j < ENTRIES; j++) begin
						if (slot_used[j] && (victim < 0 || slot_uses[j] < slot_uses[victim] ||
								(slot_uses[j] == slot_uses[victim] &&
								 slot_rank[j] > slot_rank[victim])))
							victim = j;
					end
					if (victim >= 0) begin
						r.evicted = 1'b1;
						r.evicted_key = slot_key[victim];
						gone_rank = slot_rank[victim];
						for (j = 0; j < ENTRIES; j++) begin
							if (slot_used[j] && j != victim && slot_rank[j] > gone_rank)
								slot_rank[j]--;
						end
						slot_used[victim] = 1'b0;
						if (fill_level > 0)
							fill_level--;
						slot = victim;
					end
				end
				// otherwise the first free slot
				if (slot < 0) begin
					for (j = 0; j < ENTRIES; j++) begin
						if (slot < 0 && !slot_used[j])
							slot = j;
					end
				end
				if (slot >= 0) begin
					for (j = 0; j < ENTRIES; j++) begin
						if (slot_used[j])
							slot_rank[j]++;
					end
					slot_used[slot] = 1'b1;
					slot_key[slot]  = key;
					slot_data[slot] = data;
					slot_uses[slot] = COUNT_BITS'(1);
					slot_rank[slot] = 0;
					fill_level++;
				end
			end
		end
		return r;
	endfunction

	// watch both streams and the register port
	always @(posedge clk or negedge arst_n) begin
		cache_reply_t want;
		cache_reply_t got;
		cache_reply_t pred;
		if (!arst_n) begin
			for (int j = 0; j < ENTRIES; j++) begin
				slot_used[j] = 1'b0;
				slot_key[j]  = '0;
				slot_data[j] = '0;
				slot_uses[j] = '0;
				slot_rank[j] = 0;
			end
			fill_level = 0;
			capacity = CAP_RESET;
			reply_rd = 0;
			reply_wr = 0;
			reply_cnt = 0;
			error_count = 0;
			in_flight = 0;
		end else begin
			// response transfer against the oldest expectation
			if (m_tvalid && m_tready) begin
				got.hit         = m_tuser[0];
				got.evicted     = m_tuser[1];
				got.read_data   = m_tdata[DATA_W-1:0];
				got.evicted_key = m_tdata[DATA_W+KEY_W-1:DATA_W];
				if (reply_cnt == 0) begin
					$error("response with no request outstanding: tdata %h tuser %b",
						m_tdata, m_tuser);
					error_count++;
				end else begin
					want = reply_fifo[reply_rd];
					reply_rd = (reply_rd + 1) % REPLY_DEPTH;
					reply_cnt--;
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						error_count++;
					end
					if (got.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, got.read_data);
						error_count++;
					end
					if (got.evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
						error_count++;
					end
					if (got.evicted_key !== want.evicted_key) begin
						$error("evicted_key: expected %h, got %h",
							want.evicted_key, got.evicted_key);
						error_count++;
					end
				end
			end
			if (cfg_we)
				capacity = cfg_wdata;
			// request transfer: predict its response
			if (s_tvalid && s_tready) begin
				pred = serve_request(s_tuser, s_tdata[KEY_W-1:0],
					s_tdata[KEY_W+DATA_W-1:KEY_W]);
				if (reply_cnt == REPLY_DEPTH) begin
					$error("too many requests outstanding");
					error_count++;
				end else begin
					reply_fifo[reply_wr] = pred;
					reply_wr = (reply_wr + 1) % REPLY_DEPTH;
					reply_cnt++;
				end
			end
			in_flight = reply_cnt;
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench top for the lfu cache table: request stimulus, response stalls and verdict
module testbench;
	import lfu_pkg::*;

	localparam int REPLY_LATENCY = 2 * ENTRIES_DEF + 6;
	localparam int QUIET_LIMIT   = 2000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CAP_W-1:0]        cfg_wdata;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [KEY_W+DATA_W-1:0] s_tdata;   // req_key, req_data
	logic                    s_tuser;   // kind
	logic                    m_tvalid;
	logic                    m_tready;
	logic [DATA_W+KEY_W-1:0] m_tdata;   // read_data, evicted_key
	logic [1:0]              m_tuser;   // hit, evicted
	int                      error_count;
	int                      in_flight;
	int                      quiet_cycles = 0;
	int                      burst_left = 0;
	bit                      gaps_on = 1'b1;

	lfu_cache_table_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	lfu_cache_checker table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.error_count (error_count),
		.in_flight   (in_flight)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// end the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// response side: shifting stall pattern with an occasional long hold-off
	initial begin : reply_side
		int unsigned cycle_no;
		int unsigned mode;
		m_tready = 1'b0;
		cycle_no = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			cycle_no++;
			if (cycle_no % 64 == 0)
				mode = $urandom_range(0, 3);
			if (cycle_no % 15000 == 3000) begin
				m_tready <= 1'b0;
				repeat (600) @(negedge clk);
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= cycle_no[2];
				endcase
			end
		end
	end

	// offer one request in bursts with random gaps, return once it is transferred
	task automatic push_request(input logic kind, input logic [KEY_W-1:0] key,
			input logic [DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {data, key};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait for every response to come back
	task automatic drain_requests();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		drain_requests();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		logic [KEY_W-1:0] key_pool [32];
		logic [KEY_W-1:0] key;
		logic             kind;
		int               pool_n;
		int               phase;
		int               i;
		logic [CAP_W-1:0] cap;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = KIND_GET;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset capacity: misses, inserts at the key extremes, hits, overwrite
		push_request(KIND_GET, 32'h0000_0000, 32'h1111_1111);
		push_request(KIND_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
		push_request(KIND_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
		push_request(KIND_GET, 32'h0000_0000, 32'h0);
		push_request(KIND_GET, 32'hFFFF_FFFF, 32'h0);
		push_request(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		push_request(KIND_GET, 32'h0000_0000, 32'h0);
		push_request(KIND_GET, 32'h5A5A_5A5A, 32'h0);

		// full table: least used goes first
		write_capacity(5'd2);
		push_request(KIND_PUT, 32'hA5A5_A5A5, 32'h0);
		push_request(KIND_PUT, 32'h0000_0001, 32'h1);
		push_request(KIND_PUT, 32'h8000_0000, 32'h2);
		push_request(KIND_PUT, 32'h7FFF_FFFF, 32'h3);

		// equal counts: the oldest touched goes
		write_capacity(5'd3);
		push_request(KIND_PUT, 32'h1234_5678, 32'h4);
		push_request(KIND_PUT, 32'hDEAD_BEEF, 32'h5);

		// capacity below occupancy: replace without growing
		write_capacity(5'd1);
		push_request(KIND_PUT, 32'h0F0F_0F0F, 32'h6);
		push_request(KIND_GET, 32'hDEAD_BEEF, 32'h0);

		// capacity zero: puts change nothing, gets still hit
		write_capacity(5'd0);
		push_request(KIND_PUT, 32'h0000_0000, 32'h5);
		push_request(KIND_PUT, 32'hCAFE_F00D, 32'h7);
		push_request(KIND_GET, 32'h0000_0000, 32'h0);
		push_request(KIND_GET, 32'hCAFE_F00D, 32'h0);

		// register above the table size
		write_capacity(5'd31);
		push_request(KIND_PUT, 32'hCAFE_F00D, 32'h8);
		push_request(KIND_GET, 32'hCAFE_F00D, 32'h0);

		// random phases over a small key pool so hits and evictions are common
		for (i = 0; i < 32; i++)
			key_pool[i] = $urandom();
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0: cap = 5'd16;
				1: cap = 5'd4;
				2: cap = 5'd1;
				3: cap = 5'd0;
				4: cap = 5'd31;
				5: cap = 5'd2;
				6: cap = 5'd8;
				7: cap = 5'd17;
				8: cap = 5'd5;
				default: cap = 5'd16;
			endcase
			write_capacity(cap);
			gaps_on = (phase % 3 != 1);
			pool_n = $urandom_range(2, 24);
			for (i = 0; i < pool_n; i++) begin
				if ($urandom_range(0, 2) == 0)
					key_pool[i] = $urandom();
			end
			for (i = 0; i < 80; i++) begin
				kind = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 9) == 0)
					key = $urandom();
				else
					key = key_pool[$urandom_range(0, pool_n - 1)];
				push_request(kind, key, $urandom());
			end
		end

		drain_requests();
		repeat (2 * REPLY_LATENCY) @(negedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
